>>> src/fgl_pkg.sv
// shared types and constants for the fingerprint grid locator
package fgl_pkg;

    // command codes
    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_LOCATE = 1'b1;

    localparam int FIELD_SAMPLE_BITS = 12;
    localparam int TOL_BITS          = 10;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 10'd45;

    localparam int SCREEN_X_BASE = 212;
    localparam int SCREEN_Y_BASE = 240;
    localparam int SCREEN_STEP   = 24;
    localparam int OFFSET_BASE   = 40;
    localparam int OFFSET_STEP   = 10;

    typedef struct packed {
        logic                         command;
        logic [6:0]                   point_index;
        logic [FIELD_SAMPLE_BITS-1:0] sample_top;
        logic [FIELD_SAMPLE_BITS-1:0] sample_bottom;
        logic [FIELD_SAMPLE_BITS-1:0] sample_left;
        logic [FIELD_SAMPLE_BITS-1:0] sample_right;
    } in_item_t;

    typedef struct packed {
        logic              matched;
        logic              have_fix;
        logic [3:0]        grid_column;
        logic [3:0]        grid_row;
        logic [7:0]        screen_x;
        logic [7:0]        screen_y;
        logic signed [6:0] offset_x_cm;
        logic signed [6:0] offset_y_cm;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_FINISH
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic issue;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic locate;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

>>> src/fgl_ctrl.sv
// controller state machine: accept, scan sequencing and result hand-off
module fgl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  fgl_pkg::dp_status_t status,
    output fgl_pkg::ctrl_cmd_t  cmd
);
    import fgl_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = status.locate ? ST_SCAN : ST_FINISH;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_WAIT;
                end
            end
            // last read is compared here
            ST_WAIT:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    a_scan_to_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && status.scan_last) |=> (state_reg == ST_WAIT))
        else $error("scan did not end after last address");

endmodule

>>> src/fgl_datapath.sv
// datapath: calibration memory, tolerance compare, held position and result register
module fgl_datapath #(
    parameter int STORE_DEPTH  = 128,
    parameter int GRID_POINTS  = 81,
    parameter int GRID_COLUMNS = 9,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  fgl_pkg::in_item_t                    in_data,
    input  logic                                 cfg_write,
    input  logic [fgl_pkg::TOL_BITS-1:0]         cfg_data,
    input  fgl_pkg::ctrl_cmd_t                   cmd,
    output fgl_pkg::dp_status_t                  status,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output fgl_pkg::out_item_t                   out_data
);
    import fgl_pkg::*;

    localparam int AW     = $clog2(STORE_DEPTH);
    localparam int SCAN_N = (GRID_POINTS < STORE_DEPTH) ? GRID_POINTS : STORE_DEPTH;
    localparam int DW     = ((SAMPLE_BITS > TOL_BITS) ? SAMPLE_BITS : TOL_BITS) + 2;
    localparam int EW     = 4 * SAMPLE_BITS;

    logic [EW-1:0] mem [STORE_DEPTH];
    logic [EW-1:0] rd_data_reg;
    logic [EW-1:0] smp_reg;
    logic [EW-1:0] smp_in;

    logic [TOL_BITS-1:0] tol_reg;
    logic [AW-1:0]       addr_reg;
    logic                rd_valid_reg;
    logic [3:0]          col_reg;
    logic [3:0]          row_reg;
    logic                found_reg;
    logic [3:0]          hit_col_reg;
    logic [3:0]          hit_row_reg;
    logic                fix_reg;
    logic [3:0]          held_col_reg;
    logic [3:0]          held_row_reg;
    logic                out_valid_reg;
    out_item_t           out_data_reg;

    logic                in_store_ok;
    logic                entry_match;
    logic [3:0]          chan_close;
    logic signed [DW-1:0] tol_s;
    logic signed [DW-1:0] diff [4];
    logic [3:0]          nc;
    logic [3:0]          nr;
    logic                nfix;
    out_item_t           res;

    assign smp_in = {SAMPLE_BITS'(in_data.sample_top), SAMPLE_BITS'(in_data.sample_bottom),
                     SAMPLE_BITS'(in_data.sample_left), SAMPLE_BITS'(in_data.sample_right)};

    assign in_store_ok = (in_data.command == CMD_STORE)
                         && (int'(in_data.point_index) < STORE_DEPTH);

    assign status.locate    = (in_data.command == CMD_LOCATE)
                              && (int'(in_data.point_index) >= GRID_POINTS);
    assign status.scan_last = (addr_reg == AW'(SCAN_N - 1));
    assign status.out_free  = !out_valid_reg || !out_stall;

    // calibration memory, one write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.accept && in_store_ok)
        begin
            mem[AW'(in_data.point_index)] <= smp_in;
        end
        rd_data_reg <= mem[addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            smp_reg <= smp_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_write)
        begin
            tol_reg <= cfg_data;
        end
    end

    // signed window compare on all four channels
    assign tol_s = DW'(signed'({1'b0, tol_reg}));

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            diff[k] = DW'(signed'({1'b0, smp_reg[k*SAMPLE_BITS +: SAMPLE_BITS]}))
                      - DW'(signed'({1'b0, rd_data_reg[k*SAMPLE_BITS +: SAMPLE_BITS]}));
            chan_close[k] = (diff[k] < tol_s) && (diff[k] > -tol_s);
        end
    end

    assign entry_match = rd_valid_reg && (&chan_close);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            found_reg    <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.issue;
            if (cmd.accept)
            begin
                addr_reg  <= '0;
                col_reg   <= '0;
                row_reg   <= '0;
                found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.issue)
                begin
                    addr_reg <= addr_reg + 1'b1;
                end
                // column and row of the entry under compare
                if (rd_valid_reg)
                begin
                    if (col_reg == 4'(GRID_COLUMNS - 1))
                    begin
                        col_reg <= '0;
                        row_reg <= row_reg + 1'b1;
                    end
                    else
                    begin
                        col_reg <= col_reg + 1'b1;
                    end
                end
                if (entry_match)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // later matches overwrite earlier ones
    always_ff @(posedge clk)
    begin
        if (entry_match)
        begin
            hit_col_reg <= col_reg;
            hit_row_reg <= row_reg;
        end
    end

    assign nc   = found_reg ? hit_col_reg : held_col_reg;
    assign nr   = found_reg ? hit_row_reg : held_row_reg;
    assign nfix = fix_reg || found_reg;

    always_comb
    begin
        res             = '0;
        res.matched     = found_reg;
        res.have_fix    = nfix;
        res.grid_column = nc;
        res.grid_row    = nr;
        if (nfix)
        begin
            res.screen_x    = 8'(SCREEN_X_BASE - SCREEN_STEP * int'(nc));
            res.screen_y    = 8'(SCREEN_Y_BASE - SCREEN_STEP * int'(nr));
            res.offset_x_cm = 7'(OFFSET_BASE - OFFSET_STEP * int'(nc));
            res.offset_y_cm = 7'(OFFSET_STEP * int'(nr) - OFFSET_BASE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_reg       <= 1'b0;
            held_col_reg  <= '0;
            held_row_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                fix_reg       <= nfix;
                held_col_reg  <= nc;
                held_row_reg  <= nr;
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid_reg || !out_stall))
        else $error("result register overwritten while pending");

    a_match_has_fix: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.matched) |-> out_data_reg.have_fix)
        else $error("match reported without fix");

    a_fix_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        fix_reg |=> fix_reg)
        else $error("fix lost");

endmodule

>>> src/fingerprint_grid_locator.sv
// top level of the fingerprint grid locator
//
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_data  (fgl_pkg::in_item_t)
//  out      output     out_valid / out_stall  out_data (fgl_pkg::out_item_t)
//  cfg      input      cfg_write              cfg_data (match tolerance)
//
// a store or a short locate goes from accept straight to the finish step
// a locate scans min(GRID_POINTS, STORE_DEPTH) entries, paced by the
// single read port of the calibration memory, one entry a cycle
// the result sits in an output register; the next transaction is accepted
// while it waits, and the block only holds in its last step if it is still full
// reset is asynchronous, active low; the memory needs no clearing
module fingerprint_grid_locator #(
    parameter int STORE_DEPTH  = 128,
    parameter int GRID_POINTS  = 81,
    parameter int GRID_COLUMNS = 9,
    parameter int SAMPLE_BITS  = 12
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  fgl_pkg::in_item_t            in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output fgl_pkg::out_item_t           out_data,
    input  logic                         cfg_write,
    input  logic [fgl_pkg::TOL_BITS-1:0] cfg_data
);
    import fgl_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    fgl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    fgl_datapath #(
        .STORE_DEPTH  (STORE_DEPTH),
        .GRID_POINTS  (GRID_POINTS),
        .GRID_COLUMNS (GRID_COLUMNS),
        .SAMPLE_BITS  (SAMPLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
